FILE: src/gccd_pkg.sv
`default_nettype none

package gccd_pkg;

  localparam int unsigned CoordBits  = 11;
  localparam int unsigned ClassBits  = 8;
  localparam int unsigned ExtentBits = 12;
  localparam int unsigned ThreshBits = 20;
  localparam int unsigned AddrBits   = 5;
  localparam int unsigned DataBits   = 32;

  // grid shape; the result fields are sized for four columns
  localparam int unsigned GridColumns = 4;
  localparam int unsigned GridRows    = 4;

  // sample every fourth column: low x bits must be zero
  localparam int unsigned SampleBits = 2;

  localparam int unsigned MinClusterLength = 2;
  localparam int unsigned EndGreenRow      = 1;
  localparam int unsigned MinGreenCount    = 2;
  localparam int unsigned CenterMax        = 2047;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_SHORT_RUN = 2'd1;
  localparam logic [1:0] STATUS_LOW_GREEN = 2'd2;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH      = 3'd0,
    REG_IMAGE_HEIGHT     = 3'd1,
    REG_WHITE_THRESHOLD  = 3'd2,
    REG_GREEN_THRESHOLD  = 3'd3,
    REG_WHITE_CODE       = 3'd4,
    REG_ROBOT_WHITE_CODE = 3'd5,
    REG_GREEN_CODE       = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic [ClassBits-1:0] pixel_class;
    logic                 frame_end;
  } pixel_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [1:0]           run_start;
    logic [2:0]           run_length;
    logic [3:0]           green_cells;
    logic [CoordBits-1:0] center_x;
  } result_t;

  typedef struct packed {
    logic [ExtentBits-1:0] image_width;
    logic [ExtentBits-1:0] image_height;
    logic [ThreshBits-1:0] white_threshold;
    logic [ThreshBits-1:0] green_threshold;
    logic [ClassBits-1:0]  white_code;
    logic [ClassBits-1:0]  robot_white_code;
    logic [ClassBits-1:0]  green_code;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    image_width:      12'd640,
    image_height:     12'd480,
    white_threshold:  20'd2880,
    green_threshold:  20'd288,
    white_code:       8'd1,
    robot_white_code: 8'd2,
    green_code:       8'd3
  };

  typedef struct packed {
    logic load;
    logic scan_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic stage_valid;
    logic stage_last;
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/grid_color_cluster_detector.sv
// Channel  | Direction | Handshake              | Payload
// pixel    | in        | in_valid_i/in_ready_o  | in_data_i  (pixel_t)
// result   | out       | out_valid_o/out_ready_i| out_data_o (result_t)
// config   | in        | APB psel/penable       | paddr, pwdata, prdata
//
// One pixel per cycle while intake is open: each pixel is staged; a sampled white pixel
// bumps its column counter, a sampled green one its cell counter. A frame_end pixel
// stops intake until it is counted, the columns scanned and the result register loaded.
// The result waits in its own register; the next frame streams in meanwhile, and only
// the next frame end waits for the result to be taken.
// Reset (rst_ni, asynchronous) clears all counters and loads the register defaults.
`default_nettype none

module grid_color_cluster_detector #(
  parameter int unsigned COUNT_BITS   = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gccd_pkg::pixel_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gccd_pkg::result_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gccd_pkg::AddrBits-1:0] paddr,
  input  logic [gccd_pkg::DataBits-1:0] pwdata,
  output logic [gccd_pkg::DataBits-1:0] prdata,
  output logic                          pready
);
  import gccd_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  gccd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gccd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gccd_dp #(
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: src/gccd_regs.sv
`default_nettype none

module gccd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gccd_pkg::AddrBits-1:0] paddr,
  input  logic [gccd_pkg::DataBits-1:0] pwdata,
  output logic [gccd_pkg::DataBits-1:0] prdata,
  output logic                          pready,
  output gccd_pkg::cfg_t                cfg_o
);
  import gccd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[AddrBits-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:      cfg_d.image_width      = pwdata[ExtentBits-1:0];
        REG_IMAGE_HEIGHT:     cfg_d.image_height     = pwdata[ExtentBits-1:0];
        REG_WHITE_THRESHOLD:  cfg_d.white_threshold  = pwdata[ThreshBits-1:0];
        REG_GREEN_THRESHOLD:  cfg_d.green_threshold  = pwdata[ThreshBits-1:0];
        REG_WHITE_CODE:       cfg_d.white_code       = pwdata[ClassBits-1:0];
        REG_ROBOT_WHITE_CODE: cfg_d.robot_white_code = pwdata[ClassBits-1:0];
        REG_GREEN_CODE:       cfg_d.green_code       = pwdata[ClassBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:      prdata = DataBits'(cfg_q.image_width);
      REG_IMAGE_HEIGHT:     prdata = DataBits'(cfg_q.image_height);
      REG_WHITE_THRESHOLD:  prdata = DataBits'(cfg_q.white_threshold);
      REG_GREEN_THRESHOLD:  prdata = DataBits'(cfg_q.green_threshold);
      REG_WHITE_CODE:       prdata = DataBits'(cfg_q.white_code);
      REG_ROBOT_WHITE_CODE: prdata = DataBits'(cfg_q.robot_white_code);
      REG_GREEN_CODE:       prdata = DataBits'(cfg_q.green_code);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/gccd_ctrl.sv
`default_nettype none

module gccd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gccd_pkg::dp_status_t status_i,
  output gccd_pkg::dp_cmd_t    cmd_o
);
  import gccd_pkg::*;

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    in_ready;
  logic    last_staged;
  dp_cmd_t cmd;

  assign last_staged = status_i.stage_valid && status_i.stage_last;

  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_q)
      S_RUN: begin
        // hold off new pixels while the frame's last one is counted
        in_ready = !last_staged;
        if (last_staged) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.emit = 1'b1;
          state_d  = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
    cmd.load = in_valid_i && in_ready;
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

FILE: src/gccd_dp.sv
`default_nettype none

module gccd_dp #(
  parameter int unsigned COUNT_BITS   = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gccd_pkg::cfg_t       cfg_i,
  input  gccd_pkg::pixel_t     in_data_i,
  input  gccd_pkg::dp_cmd_t    cmd_i,
  output gccd_pkg::dp_status_t status_o,
  output gccd_pkg::result_t    out_data_o
);
  import gccd_pkg::*;

  localparam int unsigned ColBits      = $clog2(GridColumns);
  localparam int unsigned RowBits      = $clog2(GridRows);
  localparam int unsigned ColBoundBits = ExtentBits + ColBits;
  localparam int unsigned RowBoundBits = ExtentBits + RowBits;
  localparam int unsigned CmpBits      = (COUNT_BITS > ThreshBits) ? COUNT_BITS : ThreshBits;
  localparam int unsigned LenBits      = ColBits + 1;
  localparam int unsigned GreenBits    = $clog2((EndGreenRow + 1) * GridColumns + 1);
  localparam int unsigned SpanBits     = ColBits + 2;
  localparam int unsigned ProdBits     = SpanBits + CoordBits;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // grid geometry, refreshed from the registers every cycle
  logic [ExtentBits-1:0]   col_div, row_div, col_pitch, row_size;
  logic [ColBoundBits-1:0] col_bound_q [1:GridColumns-1];
  logic [RowBoundBits-1:0] row_bound_q [1:GridRows-1];
  logic [CoordBits-1:0]    col_w_q;

  assign col_div   = ExtentBits'(cfg_i.image_width / GridColumns);
  assign row_div   = ExtentBits'(cfg_i.image_height / GridRows);
  assign col_pitch = (col_div == '0) ? ExtentBits'(1) : col_div;
  assign row_size  = (row_div == '0) ? ExtentBits'(1) : row_div;

  always_ff @(posedge clk_i) begin
    for (int k = 1; k < GridColumns; k++) begin
      col_bound_q[k] <= ColBoundBits'(k) * ColBoundBits'(col_pitch);
    end
    for (int k = 1; k < GridRows; k++) begin
      row_bound_q[k] <= RowBoundBits'(k) * RowBoundBits'(row_size);
    end
    col_w_q <= CoordBits'(col_div);
  end

  // pixel stage
  pixel_t pix_q;
  logic   stage_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= cmd_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= in_data_i;
    end
  end

  // grid index: count the boundaries at or below the coordinate, clamps by itself
  logic [ColBits-1:0] pix_col;
  logic [RowBits-1:0] pix_row;

  always_comb begin
    pix_col = '0;
    for (int k = 1; k < GridColumns; k++) begin
      if (ColBoundBits'(pix_q.pixel_x) >= col_bound_q[k]) begin
        pix_col = pix_col + ColBits'(1);
      end
    end
    pix_row = '0;
    for (int k = 1; k < GridRows; k++) begin
      if (RowBoundBits'(pix_q.pixel_y) >= row_bound_q[k]) begin
        pix_row = pix_row + RowBits'(1);
      end
    end
  end

  logic sampled, is_white, is_green;

  assign sampled  = (pix_q.pixel_x[SampleBits-1:0] == '0);
  assign is_white = (pix_q.pixel_class == cfg_i.white_code) ||
                    (pix_q.pixel_class == cfg_i.robot_white_code);
  assign is_green = (pix_q.pixel_class == cfg_i.green_code);

  // counters
  logic [COUNT_BITS-1:0] white_q [GridColumns];
  logic [COUNT_BITS-1:0] green_q [GridRows][GridColumns];
  logic [COUNT_BITS-1:0] green_col [GridRows];
  logic [COUNT_BITS-1:0] white_rd, green_rd, white_inc, green_inc;
  logic [ColBits-1:0]    scan_q, rd_col;

  // one column read port: the pixel column while counting, the scan column otherwise
  assign rd_col = stage_valid_q ? pix_col : scan_q;

  always_comb begin
    for (int r = 0; r < GridRows; r++) begin
      green_col[r] = green_q[r][rd_col];
    end
  end

  assign white_rd  = white_q[rd_col];
  assign green_rd  = green_col[pix_row];
  assign white_inc = (white_rd == CountMax) ? white_rd : white_rd + COUNT_BITS'(1);
  assign green_inc = (green_rd == CountMax) ? green_rd : green_rd + COUNT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q <= '{default: '0};
      green_q <= '{default: '0};
    end else if (cmd_i.emit) begin
      white_q <= '{default: '0};
      green_q <= '{default: '0};
    end else if (stage_valid_q && sampled) begin
      if (is_white) begin
        white_q[pix_col] <= white_inc;
      end
      if (is_green) begin
        green_q[pix_row][pix_col] <= green_inc;
      end
    end
  end

  // column scan: run search and green cell count
  logic                 found_q;
  logic [ColBits-1:0]   start_q;
  logic [LenBits-1:0]   len_q;
  logic [GreenBits-1:0] green_cnt_q, green_step;
  logic                 white_hit, adjacent, scan_last;

  assign white_hit = CmpBits'(white_rd) > CmpBits'(cfg_i.white_threshold);
  assign adjacent  = (LenBits'(start_q) + len_q) == LenBits'(scan_q);
  assign scan_last = (scan_q == ColBits'(GridColumns - 1));

  always_comb begin
    green_step = '0;
    for (int r = 0; r <= EndGreenRow; r++) begin
      if (CmpBits'(green_col[r]) > CmpBits'(cfg_i.green_threshold)) begin
        green_step = green_step + GreenBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      found_q     <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      green_cnt_q <= '0;
    end else if (cmd_i.emit) begin
      scan_q      <= '0;
      found_q     <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      green_cnt_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_q      <= scan_last ? '0 : scan_q + ColBits'(1);
      green_cnt_q <= green_cnt_q + green_step;
      if (white_hit) begin
        if (found_q && adjacent) begin
          len_q <= len_q + LenBits'(1);
        end else if (!found_q || (len_q < LenBits'(MinClusterLength))) begin
          // restart only while no run of full length is held
          found_q <= 1'b1;
          start_q <= scan_q;
          len_q   <= LenBits'(1);
        end
      end
    end
  end

  // result
  logic [SpanBits-1:0]  span;
  logic [ProdBits-1:0]  product, half;
  logic [CoordBits-1:0] center;
  result_t              result, out_q;

  assign span    = (SpanBits'(start_q) << 1) + SpanBits'(len_q);
  assign product = ProdBits'(span) * ProdBits'(col_w_q);
  assign half    = product >> 1;
  assign center  = (half > ProdBits'(CenterMax)) ? CoordBits'(CenterMax) : CoordBits'(half);

  always_comb begin
    result.run_start   = 2'(start_q);
    result.run_length  = 3'(len_q);
    result.green_cells = 4'(green_cnt_q);
    result.center_x    = '0;
    if (len_q < LenBits'(MinClusterLength)) begin
      result.status = STATUS_SHORT_RUN;
    end else if (green_cnt_q < GreenBits'(MinGreenCount)) begin
      result.status = STATUS_LOW_GREEN;
    end else begin
      result.status   = STATUS_FOUND;
      result.center_x = center;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= result;
    end
  end

  assign out_data_o = out_q;
  assign status_o   = '{stage_valid: stage_valid_q,
                        stage_last:  pix_q.frame_end,
                        scan_last:   scan_last};

endmodule

`default_nettype wire

FILE: src/gccd_checker.sv
`default_nettype none

module gccd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input gccd_pkg::pixel_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gccd_pkg::result_t out_data_o
);
  import gccd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.frame_end |=> !in_ready_o)
    else $error("pixel intake continued after frame end");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_FOUND) ||
                    (out_data_o.status == STATUS_SHORT_RUN) ||
                    (out_data_o.status == STATUS_LOW_GREEN))
    else $error("undefined status code");

  a_center_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_FOUND) |-> out_data_o.center_x == '0)
    else $error("center reported without a cluster");

endmodule

bind grid_color_cluster_detector gccd_checker u_gccd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
